@@ hdl/csba_pkg.sv @@
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types, codes and helpers of the clipped sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csba_pkg;

  localparam int MAX_SIDE_DEF = 256;
  localparam int PIX_W        = 32;
  localparam int IN_DATA_W    = 72;
  localparam int IN_USER_W    = 3;
  localparam int OUT_DATA_W   = 40;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ALPHA  = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE        = 3'd0,
    OP_BLEND        = 3'd1,
    OP_FILL         = 3'd2,
    OP_BEGIN_COPY   = 3'd3,
    OP_BEGIN_BLEND  = 3'd4,
    OP_SPRITE_PIXEL = 3'd5,
    OP_READ         = 3'd6,
    OP_STEP_FRAME   = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_NO_SPRITE = 2'd2,
    ST_LAST      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_BLEND = 2'd2
  } sprite_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_MUL,
    S_WR,
    S_FILL,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic rd_en;
    logic mul_en;
    logic wr_en;
    logic fill_en;
    logic fin;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    hit;
    logic    spr_on;
    logic    spr_blend;
    logic    fill_last;
    logic    out_free;
  } dp_sts_t;

  // floor(v/255), exact for any v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [17:0] t;
    t = 18'(v) + 18'(v[15:8]) + 18'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ hdl/csba_ram.sv @@
// ----------------------------------------------------------------------------
// csba_ram
// Generic single-write, single-read RAM with byte enables, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic [WIDTH/8-1:0]       we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // byte-lane writes
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH/8; i++) begin
      if (we[i]) begin
        mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/csba_ctrl.sv @@
// ----------------------------------------------------------------------------
// csba_ctrl
// Command sequencer: decode, read, multiply, write, fill sweep and finish.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_ctrl
  import csba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_DEC;
      S_DEC: begin
        unique case (sts.op)
          OP_WRITE:  state_nxt = sts.hit ? S_WR : S_FIN;
          OP_BLEND:  state_nxt = sts.hit ? S_RD : S_FIN;
          OP_READ:   state_nxt = sts.hit ? S_RD : S_FIN;
          OP_FILL:   state_nxt = S_FILL;
          OP_SPRITE_PIXEL: begin
            if (sts.spr_on && sts.hit) begin
              state_nxt = sts.spr_blend ? S_RD : S_WR;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default:   state_nxt = S_FIN;
        endcase
      end
      S_RD:   state_nxt = (sts.op == OP_READ) ? S_FIN : S_MUL;
      S_MUL:  state_nxt = S_WR;
      S_WR:   state_nxt = S_FIN;
      S_FILL: if (sts.fill_last) state_nxt = S_FIN;
      S_FIN:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    in_tready   = (state_r == S_IDLE);
    cmd.latch   = (state_r == S_IDLE) && in_tvalid;
    cmd.rd_en   = (state_r == S_RD);
    cmd.mul_en  = (state_r == S_MUL);
    cmd.wr_en   = (state_r == S_WR);
    cmd.fill_en = (state_r == S_FILL);
    cmd.fin     = (state_r == S_FIN) && sts.out_free;
  end

endmodule

`default_nettype wire

@@ hdl/csba_dp.sv @@
// ----------------------------------------------------------------------------
// csba_dp
// Datapath: command fields, sprite state, clipping, blend math, store, result.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_dp
  import csba_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire ctl_cmd_t              cmd,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output dp_sts_t                    sts
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [8:0] dw_r, dh_r;
  logic       dha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r  <= 9'd256;
      dh_r  <= 9'd256;
      dha_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEST_WIDTH)  dw_r  <= cfg_wdata;
      if (cfg_index == CFG_DEST_HEIGHT) dh_r  <= cfg_wdata;
      if (cfg_index == CFG_DEST_ALPHA)  dha_r <= cfg_wdata[0];
    end
  end

  logic [8:0] eff_w, eff_h;
  assign eff_w = (int'(dw_r) > MAX_SIDE) ? 9'(MAX_SIDE) : dw_r;
  assign eff_h = (int'(dh_r) > MAX_SIDE) ? 9'(MAX_SIDE) : dh_r;

  // input fields
  opcode_t    in_op;
  logic [9:0] in_x, in_y;
  logic [7:0] in_b, in_g, in_r, in_a;
  logic [8:0] in_sw, in_sh;
  logic       in_sa;

  assign in_op = opcode_t'(in_tuser);
  assign in_x  = in_tdata[9:0];
  assign in_y  = in_tdata[19:10];
  assign in_b  = in_tdata[27:20];
  assign in_g  = in_tdata[35:28];
  assign in_r  = in_tdata[43:36];
  assign in_a  = in_tdata[51:44];
  assign in_sw = in_tdata[60:52];
  assign in_sh = in_tdata[69:61];
  assign in_sa = in_tdata[70];

  // sprite state
  logic [9:0]   org_x_r, org_y_r;
  logic [8:0]   spw_r, sph_r, col_r, row_r;
  sprite_mode_t mode_r;
  logic         spa_r;
  logic         changed_r, frame_r, update_r;

  // target pixel of the incoming command
  logic [11:0] px, py;
  logic        in_inside;
  logic [AW-1:0] in_addr;

  always_comb begin
    if (in_op == OP_SPRITE_PIXEL) begin
      px = {{2{org_x_r[9]}}, org_x_r} - {4'b0, spw_r[8:1]} + {3'b0, col_r};
      py = {{2{org_y_r[9]}}, org_y_r} - {4'b0, sph_r[8:1]} + {3'b0, row_r};
    end else begin
      px = {{2{in_x[9]}}, in_x};
      py = {{2{in_y[9]}}, in_y};
    end
    in_inside = !px[11] && !py[11] && (px[10:0] < {2'b0, eff_w}) &&
                (py[10:0] < {2'b0, eff_h});
    in_addr = AW'(32'(py[8:0]) * 32'(MAX_SIDE) + 32'(px[8:0]));
  end

  // latched command
  opcode_t     op_r;
  logic [9:0]  x_r, y_r;
  logic [7:0]  b_r, g_r, r_r, a_r;
  logic [8:0]  sw_r, sh_r;
  logic        sa_r, inside_r;
  logic [AW-1:0] addr_r, fill_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_op;
      x_r      <= in_x;
      y_r      <= in_y;
      b_r      <= in_b;
      g_r      <= in_g;
      r_r      <= in_r;
      a_r      <= in_a;
      sw_r     <= in_sw;
      sh_r     <= in_sh;
      sa_r     <= in_sa;
      inside_r <= in_inside;
      addr_r   <= in_addr;
    end
  end

  // fill sweep address
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      fill_r <= '0;
    end else if (cmd.fill_en) begin
      fill_r <= fill_r + AW'(1);
    end
  end

  // pixel store
  logic [3:0]       ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] ram_wdata, rdata;

  csba_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // blend products
  logic [15:0] cp_b_r, cp_g_r, cp_r_r, ap_r;
  logic [7:0]  inv_a;
  assign inv_a = 8'd255 - a_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      cp_b_r <= 16'(b_r * a_r) + 16'(rdata[7:0]   * inv_a);
      cp_g_r <= 16'(g_r * a_r) + 16'(rdata[15:8]  * inv_a);
      cp_r_r <= 16'(r_r * a_r) + 16'(rdata[23:16] * inv_a);
      ap_r   <= 16'(rdata[31:24] * inv_a);
    end
  end

  logic       blend_path;
  logic [8:0] na;
  logic [7:0] na_sat;
  assign blend_path = (op_r == OP_BLEND) ||
                      ((op_r == OP_SPRITE_PIXEL) && (mode_r == MODE_BLEND));
  assign na         = {1'b0, div255(ap_r)} + {1'b0, a_r};
  assign na_sat     = na[8] ? 8'hFF : na[7:0];

  // store write select
  always_comb begin
    ram_we    = '0;
    ram_waddr = addr_r;
    ram_wdata = {a_r, r_r, g_r, b_r};
    if (cmd.fill_en) begin
      ram_waddr = fill_r;
      ram_we    = {dha_r, 3'b111};
    end else if (cmd.wr_en) begin
      if (blend_path) begin
        ram_wdata = {na_sat, div255(cp_r_r), div255(cp_g_r), div255(cp_b_r)};
        ram_we    = (a_r == 8'd0) ? 4'b0000 : {dha_r, 3'b111};
      end else if (op_r == OP_SPRITE_PIXEL) begin
        ram_we = {dha_r & spa_r, 3'b111};
      end else begin
        ram_we = {dha_r, 3'b111};
      end
    end
  end

  // finish: state update and result
  logic [9:0]   org_x_nxt, org_y_nxt;
  logic [8:0]   spw_nxt, sph_nxt, col_nxt, row_nxt;
  sprite_mode_t mode_nxt;
  logic         spa_nxt, changed_nxt, frame_nxt, update_nxt;
  status_t      st;
  logic [31:0]  pix_out;
  logic         nu, fs;
  logic         col_end, row_end;

  assign col_end = ({1'b0, col_r} + 10'd1) >= {1'b0, spw_r};
  assign row_end = ({1'b0, row_r} + 10'd1) >= {1'b0, sph_r};

  always_comb begin
    org_x_nxt   = org_x_r;
    org_y_nxt   = org_y_r;
    spw_nxt     = spw_r;
    sph_nxt     = sph_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    mode_nxt    = mode_r;
    spa_nxt     = spa_r;
    changed_nxt = changed_r;
    frame_nxt   = frame_r;
    update_nxt  = update_r;
    st          = ST_DONE;
    pix_out     = '0;
    nu          = 1'b0;
    fs          = 1'b0;
    unique case (op_r)
      OP_WRITE, OP_BLEND: begin
        if (inside_r) changed_nxt = 1'b1;
        else st = ST_OUTSIDE;
      end
      OP_FILL: changed_nxt = 1'b1;
      OP_BEGIN_COPY, OP_BEGIN_BLEND: begin
        if (sw_r == 9'd0 || sh_r == 9'd0) begin
          mode_nxt = MODE_NONE;
          st       = ST_NO_SPRITE;
        end else begin
          spw_nxt   = (int'(sw_r) > MAX_SIDE) ? 9'(MAX_SIDE) : sw_r;
          sph_nxt   = (int'(sh_r) > MAX_SIDE) ? 9'(MAX_SIDE) : sh_r;
          org_x_nxt = x_r;
          org_y_nxt = y_r;
          col_nxt   = '0;
          row_nxt   = '0;
          spa_nxt   = sa_r;
          mode_nxt  = (op_r == OP_BEGIN_BLEND && sa_r) ? MODE_BLEND : MODE_COPY;
        end
      end
      OP_SPRITE_PIXEL: begin
        if (mode_r == MODE_NONE) begin
          st = ST_NO_SPRITE;
        end else begin
          if (inside_r) changed_nxt = 1'b1;
          else st = ST_OUTSIDE;
          if (col_end && row_end) begin
            mode_nxt = MODE_NONE;
            col_nxt  = '0;
            row_nxt  = '0;
            st       = ST_LAST;
          end else if (col_end) begin
            col_nxt = '0;
            row_nxt = row_r + 9'd1;
          end else begin
            col_nxt = col_r + 9'd1;
          end
        end
      end
      OP_READ: begin
        if (inside_r) begin
          pix_out = {dha_r ? rdata[31:24] : 8'hFF, rdata[23:0]};
        end else begin
          st = ST_OUTSIDE;
        end
      end
      OP_STEP_FRAME: begin
        if (changed_r) begin
          update_nxt  = 1'b1;
          changed_nxt = 1'b0;
          frame_nxt   = ~frame_r;
        end else begin
          update_nxt = 1'b0;
        end
        nu = update_nxt;
        fs = frame_nxt;
      end
      default: st = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r   <= '0;
      org_y_r   <= '0;
      spw_r     <= '0;
      sph_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      mode_r    <= MODE_NONE;
      spa_r     <= 1'b0;
      changed_r <= 1'b1;
      frame_r   <= 1'b0;
      update_r  <= 1'b0;
    end else if (cmd.fin) begin
      org_x_r   <= org_x_nxt;
      org_y_r   <= org_y_nxt;
      spw_r     <= spw_nxt;
      sph_r     <= sph_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      mode_r    <= mode_nxt;
      spa_r     <= spa_nxt;
      changed_r <= changed_nxt;
      frame_r   <= frame_nxt;
      update_r  <= update_nxt;
    end
  end

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r <= {4'b0, fs, nu, st, pix_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status to controller
  always_comb begin
    sts.op        = op_r;
    sts.hit       = inside_r;
    sts.spr_on    = (mode_r != MODE_NONE);
    sts.spr_blend = (mode_r == MODE_BLEND);
    sts.fill_last = (fill_r == AW'(DEPTH - 1));
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

`default_nettype wire

@@ hdl/clipped_sprite_blitter_alpha.sv @@
// Each command is decoded and finished; a write or sprite copy adds a write
// state, a read a read state, a blend read, multiply and write states.
// Throughput: one command at a time through the store's single
// read-modify-write path, so a new command is taken once the last finishes.
// Reset (rst_n, synchronous, active low) clears control, sprite and frame
// state; the pixel store holds no reset and is undefined until written.
// ----------------------------------------------------------------------------
// clipped_sprite_blitter_alpha
// Top level: BGRA pixel store with clipped sprite copy and alpha blending.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_sprite_blitter_alpha
  import csba_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // x_pos, y_pos, blue, green, red, alpha, sprite_width, sprite_height,
  // sprite_has_alpha, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_blue, out_green, out_red, out_alpha, status, needs_update,
  // frame_select, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  csba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csba_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

endmodule

`default_nettype wire

@@ hdl/csba_chk.sv @@
// ----------------------------------------------------------------------------
// csba_chk
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csba_chk
  import csba_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pixel bytes only come with a done status
  a_pix_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] != 32'd0) |-> out_tdata[33:32] == ST_DONE)
    else $error("pixel data with non-done status");

  // no result in the cycle after a transfer into an empty output
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clipped_sprite_blitter_alpha csba_chk u_chk (.*);

`default_nettype wire

@@ tb/clipped_sprite_blitter_alpha_test.sv @@
// ----------------------------------------------------------------------------
// clipped_sprite_blitter_alpha_test
// Self-checking bench for the sprite blitter. A behavioral predictor keeps
// its own pixel store, sprite and frame state, and works out the response
// of every accepted command. A checker compares each result transfer field
// by field. Directed cases cover clipping, blending, sprites and frame
// flags. Random phases follow under several destination settings.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_sprite_blitter_alpha_test;
  import csba_pkg::*;

  localparam int SIDE = 256;

  typedef struct {
    logic [7:0] b, g, r, a;
    status_t    st;
    logic       nu, fs;
  } blit_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  clipped_sprite_blitter_alpha u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] pix_mem [SIDE*SIDE];
  logic [8:0]  dst_w = 9'd256, dst_h = 9'd256;
  logic        dst_alpha = 1'b1;
  logic [9:0]  spr_cx, spr_cy;
  int          spr_w, spr_h, spr_col, spr_row;
  sprite_mode_t spr_mode;
  logic        spr_alpha, chg_flag, frm_flag, upd_flag;

  blit_resp_t  resp_q[$];
  int          errors = 0;
  int          n_items = 0, n_results = 0, n_fills = 0, n_sprites = 0;
  bit          gaps_on = 1'b1;
  int          hold_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic int eff_side(input logic [8:0] v);
    return (v > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic bit on_dest(input int x, input int y);
    return x >= 0 && y >= 0 && x < eff_side(dst_w) && y < eff_side(dst_h);
  endfunction

  function automatic void put_px(input int idx, input logic [31:0] c, input bit wa);
    logic [31:0] p;
    p = pix_mem[idx];
    p[23:0] = c[23:0];
    if (wa) p[31:24] = c[31:24];
    pix_mem[idx] = p;
  endfunction

  function automatic void blend_px(input int idx, input logic [31:0] c);
    logic [31:0] p, res;
    int a, na;
    p = pix_mem[idx];
    a = c[31:24];
    if (a == 0) return;
    for (int k = 0; k < 3; k++)
      res[8*k +: 8] = (int'(c[8*k +: 8]) * a + int'(p[8*k +: 8]) * (255 - a)) / 255;
    if (dst_alpha) begin
      na = (int'(p[31:24]) * (255 - a)) / 255 + a;
      res[31:24] = (na > 255) ? 8'd255 : na[7:0];
    end else begin
      res[31:24] = p[31:24];
    end
    pix_mem[idx] = res;
  endfunction

  function automatic blit_resp_t blit_predict(input opcode_t op, input logic [IN_DATA_W-1:0] d);
    blit_resp_t rs;
    int x, y, px, py, sw, sh;
    logic [31:0] c;
    logic sa;
    bit last;
    x = int'($signed(d[9:0]));
    y = int'($signed(d[19:10]));
    c = d[51:20];
    sw = d[60:52];
    sh = d[69:61];
    sa = d[70];
    rs = '{8'd0, 8'd0, 8'd0, 8'd0, ST_DONE, 1'b0, 1'b0};
    case (op)
      OP_WRITE, OP_BLEND: begin
        if (!on_dest(x, y)) rs.st = ST_OUTSIDE;
        else begin
          if (op == OP_WRITE) put_px(y*SIDE + x, c, dst_alpha);
          else blend_px(y*SIDE + x, c);
          chg_flag = 1'b1;
        end
      end
      OP_FILL: begin
        for (int k = 0; k < SIDE*SIDE; k++) put_px(k, c, dst_alpha);
        chg_flag = 1'b1;
      end
      OP_BEGIN_COPY, OP_BEGIN_BLEND: begin
        if (sw == 0 || sh == 0) begin
          spr_mode = MODE_NONE;
          rs.st = ST_NO_SPRITE;
        end else begin
          spr_w = (sw > SIDE) ? SIDE : sw;
          spr_h = (sh > SIDE) ? SIDE : sh;
          spr_cx = d[9:0];
          spr_cy = d[19:10];
          spr_col = 0;
          spr_row = 0;
          spr_alpha = sa;
          spr_mode = (op == OP_BEGIN_BLEND && sa) ? MODE_BLEND : MODE_COPY;
        end
      end
      OP_SPRITE_PIXEL: begin
        if (spr_mode == MODE_NONE) rs.st = ST_NO_SPRITE;
        else begin
          px = int'($signed(spr_cx)) - spr_w / 2 + spr_col;
          py = int'($signed(spr_cy)) - spr_h / 2 + spr_row;
          if (on_dest(px, py)) begin
            if (spr_mode == MODE_BLEND) blend_px(py*SIDE + px, c);
            else put_px(py*SIDE + px, c, dst_alpha && spr_alpha);
            chg_flag = 1'b1;
          end else begin
            rs.st = ST_OUTSIDE;
          end
          last = (spr_col + 1 >= spr_w) && (spr_row + 1 >= spr_h);
          if (last) begin
            spr_mode = MODE_NONE;
            spr_col = 0;
            spr_row = 0;
            rs.st = ST_LAST;
          end else if (spr_col + 1 >= spr_w) begin
            spr_col = 0;
            spr_row++;
          end else begin
            spr_col++;
          end
        end
      end
      OP_READ: begin
        if (!on_dest(x, y)) rs.st = ST_OUTSIDE;
        else begin
          {rs.r, rs.g, rs.b} = pix_mem[y*SIDE + x][23:0];
          rs.a = dst_alpha ? pix_mem[y*SIDE + x][31:24] : 8'd255;
        end
      end
      default: begin
        if (chg_flag) begin
          upd_flag = 1'b1;
          chg_flag = 1'b0;
          frm_flag = ~frm_flag;
        end else begin
          upd_flag = 1'b0;
        end
        rs.nu = upd_flag;
        rs.fs = frm_flag;
      end
    endcase
    return rs;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_cmd(input opcode_t op, input int x, input int y,
                          input logic [31:0] c, input int sw = 1, input int sh = 1,
                          input bit sa = 1'b0);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[9:0] = x[9:0];
    d[19:10] = y[9:0];
    d[51:20] = c;
    d[60:52] = sw[8:0];
    d[69:61] = sh[8:0];
    d[70] = sa;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    resp_q.push_back(blit_predict(op, d));
    n_items++;
    if (op == OP_FILL) n_fills++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    wait (resp_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEST_WIDTH:  dst_w = v[8:0];
      CFG_DEST_HEIGHT: dst_h = v[8:0];
      default:         dst_alpha = v[0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_dest(input int w, input int h, input bit a);
    drain();
    write_reg(CFG_DEST_WIDTH, w);
    write_reg(CFG_DEST_HEIGHT, h);
    write_reg(CFG_DEST_ALPHA, a);
  endtask

  function automatic logic [31:0] rand_color;
    return $urandom;
  endfunction

  // position biased toward the visible area and its edges
  function automatic int rand_coord(input int side);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1023) - 512;
      1: return side - 1 - $urandom_range(0, 3) + $urandom_range(0, 3);
      2: return $urandom_range(0, 3) - 2;
      default: return $urandom_range(0, (side > 0 ? side - 1 : 0));
    endcase
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    blit_resp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, out_tdata);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if ({e.fs, e.nu, e.st, e.a, e.r, e.g, e.b} !== out_tdata[35:0]) begin
          $display("%0t: mismatch exp b=%h g=%h r=%h a=%h st=%0d nu=%b fs=%b", $time,
                   e.b, e.g, e.r, e.a, e.st, e.nu, e.fs);
          $display("%0t:          act b=%h g=%h r=%h a=%h st=%0d nu=%b fs=%b", $time,
                   out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24],
                   out_tdata[33:32], out_tdata[34], out_tdata[35]);
          errors++;
        end
      end
    end
  end

  // receiver readiness: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    int stall;
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else if (stall > 0) begin
      out_tready <= 1'b0;
      stall--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall = $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_pixels;
    send_cmd(OP_FILL, 0, 0, 32'h80_40_20_10);
    send_cmd(OP_WRITE, 0, 0, 32'hFF_FF_FF_FF);
    send_cmd(OP_WRITE, 255, 255, 32'h00_00_00_00);
    send_cmd(OP_WRITE, -1, 0, 32'h12345678);
    send_cmd(OP_WRITE, 256, 5, 32'h12345678);
    send_cmd(OP_BLEND, -512, 511, 32'h12345678);
    send_cmd(OP_BLEND, 0, 0, 32'h00_11_22_33);
    send_cmd(OP_BLEND, 0, 0, 32'h7F_01_80_FE);
    send_cmd(OP_BLEND, 255, 255, 32'hFF_AA_55_C3);
    send_cmd(OP_READ, 0, 0, 0);
    send_cmd(OP_READ, 255, 255, 0);
    send_cmd(OP_READ, 511, -512, 0);
    send_cmd(OP_STEP_FRAME, 0, 0, 0);
    send_cmd(OP_STEP_FRAME, 0, 0, 0);
  endtask

  task automatic test_sprites;
    send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    send_cmd(OP_BEGIN_COPY, 3, 3, 0, 0, 4, 1);
    send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    // blend request without sprite alpha runs as a copy, clipped at a corner
    send_cmd(OP_BEGIN_BLEND, 0, 0, 0, 2, 2, 0);
    repeat (4) send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    send_cmd(OP_BEGIN_BLEND, 255, 255, 0, 3, 2, 1);
    repeat (2) send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    // a new begin replaces the active sprite
    send_cmd(OP_BEGIN_COPY, 10, 10, 0, 1, 2, 1);
    repeat (2) send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    send_cmd(OP_READ, 10, 9, 0);
    send_cmd(OP_STEP_FRAME, 0, 0, 0);
    // oversized begin saturates to the full side
    send_cmd(OP_BEGIN_COPY, 128, 0, 0, 511, 1, 1);
    repeat (SIDE) send_cmd(OP_SPRITE_PIXEL, 0, 0, rand_color());
    n_sprites += 5;
  endtask

  task automatic test_config_extremes;
    set_dest(1, 1, 0);
    send_cmd(OP_WRITE, 0, 0, 32'h55_66_77_88);
    send_cmd(OP_WRITE, 1, 0, 32'h55_66_77_88);
    send_cmd(OP_BLEND, 0, 0, 32'h80_00_00_00);
    send_cmd(OP_READ, 0, 0, 0);
    send_cmd(OP_READ, 0, 1, 0);
    set_dest(0, 256, 1);
    send_cmd(OP_WRITE, 0, 0, 32'h01020304);
    send_cmd(OP_READ, 0, 0, 0);
    set_dest(511, 300, 1);
    send_cmd(OP_READ, 0, 0, 0);
    send_cmd(OP_READ, 255, 255, 0);
    send_cmd(OP_STEP_FRAME, 0, 0, 0);
  endtask

  task automatic rand_sprite;
    int w, h, x, y, n;
    opcode_t op;
    op = $urandom_range(0, 1) ? OP_BEGIN_BLEND : OP_BEGIN_COPY;
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(0, 511);
      h = $urandom_range(0, 511);
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end
    x = rand_coord(eff_side(dst_w));
    y = rand_coord(eff_side(dst_h));
    send_cmd(op, x, y, rand_color(), w, h, $urandom_range(0, 1));
    n_sprites++;
    n = (w > SIDE ? SIDE : w) * (h > SIDE ? SIDE : h);
    // broken sequences: cut short, or too long so the tail hits no sprite
    if (n > 40 || $urandom_range(0, 7) == 0) n = $urandom_range(0, (n > 40 ? 40 : n + 2));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_cmd(OP_READ, rand_coord(eff_side(dst_w)), rand_coord(eff_side(dst_h)), 0);
      send_cmd(OP_SPRITE_PIXEL, $urandom_range(0, 1023), $urandom_range(0, 1023),
               rand_color(), $urandom_range(0, 511), $urandom_range(0, 511),
               $urandom_range(0, 1));
    end
  endtask

  task automatic rand_noise;
    opcode_t op;
    op = opcode_t'($urandom_range(0, 7));
    if (op == OP_FILL && n_fills >= 3) op = OP_READ;
    send_cmd(op, rand_coord(eff_side(dst_w)), rand_coord(eff_side(dst_h)),
             rand_color(), $urandom_range(0, 511), $urandom_range(0, 511),
             $urandom_range(0, 1));
  endtask

  task automatic test_random(input int target);
    while (n_items < target) begin
      if ($urandom_range(0, 2) == 0) rand_noise();
      else rand_sprite();
    end
  endtask

  task automatic test_backpressure;
    drain();
    hold_cycles = 300;
    repeat (30) send_cmd(OP_WRITE, $urandom_range(0, 7), $urandom_range(0, 7), rand_color());
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    spr_cx = '0; spr_cy = '0;
    spr_w = 0; spr_h = 0; spr_col = 0; spr_row = 0;
    spr_mode = MODE_NONE;
    spr_alpha = 1'b0; chg_flag = 1'b1; frm_flag = 1'b0; upd_flag = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pixels();
    test_sprites();
    test_config_extremes();
    set_dest(256, 256, 1);
    test_random(450);
    test_backpressure();
    set_dest($urandom_range(1, 40), $urandom_range(1, 40), 0);
    test_random(650);
    set_dest($urandom_range(200, 256), $urandom_range(1, 256), 1);
    test_random(800);
    gaps_on = 1'b0;
    set_dest(17, 256, 1);
    test_random(930);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d sprites, %0d fills",
             n_items, n_results, n_sprites, n_fills);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #60_000_000;
    $display("timeout with %0d results pending", resp_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
